// File: rtl/mi_pkg.sv
// Shared types for the modular inverse block.
`default_nettype none

package mi_pkg;

  // Top level to Euclid core.
  typedef struct packed {
    logic start;  // load operands and begin
    logic ack;    // result taken, core may go idle
  } core_ctrl_t;

  // Euclid core to top level.
  typedef struct packed {
    logic busy;   // item in flight or result held
    logic done;   // gcd and coefficient are valid
  } core_stat_t;

endpackage

`default_nettype wire

// File: rtl/mi_core.sv
// Extended Euclid sequencer with one shift-subtract unit for quotient and coefficient.
`default_nettype none

module mi_core #(
  parameter int WIDTH = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mi_pkg::core_ctrl_t     ctrl,
  input  wire logic [WIDTH-1:0]       a,
  input  wire logic [WIDTH-1:0]       m,
  output mi_pkg::core_stat_t          stat,
  output logic [WIDTH-1:0]            gcd,
  output logic signed [WIDTH+1:0]     coef
);

  localparam int SW = WIDTH + 2;

  typedef enum logic [1:0] {
    IDLE,
    SHIFT,
    SUB,
    DONE
  } state_t;

  state_t                 state;
  logic [WIDTH-1:0]       r0;
  logic [WIDTH-1:0]       r1;
  logic [WIDTH-1:0]       d;    // r1 scaled by 2^k
  logic signed [SW-1:0]   s0;
  logic signed [SW-1:0]   s1;
  logic signed [SW-1:0]   sd;   // s1 scaled by 2^k

  logic                   can_grow;
  logic                   ge;
  logic [WIDTH-1:0]       r_sub;
  logic signed [SW-1:0]   s_sub;

  // Next divisor doubling must not pass the partial remainder.
  assign can_grow = !d[WIDTH-1] && ({d, 1'b0} <= {1'b0, r0});
  assign ge       = (r0 >= d);
  assign r_sub    = ge ? (r0 - d) : r0;
  assign s_sub    = ge ? (s0 - sd) : s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (ctrl.start) begin
            r0    <= a;
            r1    <= m;
            d     <= m;
            s0    <= SW'(1);
            s1    <= '0;
            sd    <= '0;
            state <= (m == '0) ? DONE : SHIFT;
          end
        end
        SHIFT: begin
          if (can_grow) begin
            d  <= {d[WIDTH-2:0], 1'b0};
            sd <= sd <<< 1;
          end else begin
            state <= SUB;
          end
        end
        SUB: begin
          if (d == r1) begin
            // last quotient bit: rotate the remainder sequence
            r0    <= r1;
            r1    <= r_sub;
            s0    <= s1;
            s1    <= s_sub;
            d     <= r_sub;
            sd    <= s_sub;
            state <= (r_sub == '0) ? DONE : SHIFT;
          end else begin
            r0 <= r_sub;
            s0 <= s_sub;
            d  <= {1'b0, d[WIDTH-1:1]};
            sd <= sd >>> 1;
          end
        end
        DONE: begin
          if (ctrl.ack) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state != IDLE);
  assign stat.done = (state == DONE);
  assign gcd       = r0;
  assign coef      = s0;

endmodule

`default_nettype wire

// File: rtl/modular_inverse.sv
// Modular inverse top level: stream ports, final coefficient reduction, result register.
// Each Euclid division doubles the divisor, then subtracts one quotient bit at a time; the
//   result then moves into the output register.
// One item at a time: the next item is taken once the core has handed its result to the
//   output register, which may still be waiting on m_tready.
// Speed is set by the single shift-subtract unit inside the Euclid core.
// Reset (rst, synchronous, active high) idles the core, empties the output register and
//   holds s_tready low.
`default_nettype none

module modular_inverse #(
  parameter int WIDTH = 31
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input item
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH], zero pad above
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]        s_tdata,
  // Result item
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // inverse [WIDTH-1:0], common_divisor [2*WIDTH-1:WIDTH], zero pad above
  output logic [((2*WIDTH+7)/8)*8-1:0]             m_tdata,
  // inverse_exists [0]
  output logic [0:0]                               m_tuser
);

  localparam int SW      = WIDTH + 2;
  localparam int OUT_W   = ((2*WIDTH+7)/8)*8;

  mi_pkg::core_ctrl_t     ctrl;
  mi_pkg::core_stat_t     stat;
  logic [WIDTH-1:0]       core_gcd;
  logic signed [SW-1:0]   core_coef;

  logic [WIDTH-1:0]       modulus;     // held for the final reduction
  logic                   in_accept;
  logic                   hand_over;

  logic                   out_valid;
  logic [WIDTH-1:0]       out_inverse;
  logic [WIDTH-1:0]       out_gcd;
  logic                   out_exists;

  logic signed [SW-1:0]   mod_ext;
  logic signed [SW-1:0]   coef_up;
  logic signed [SW-1:0]   coef_down;
  logic [WIDTH-1:0]       inv_next;
  logic                   mod_zero;

  // The core is free for a new item once it has handed off its previous result.
  assign s_tready  = !rst && !stat.busy;
  assign in_accept = s_tvalid && s_tready;

  // Result moves to the output register when that register is empty or draining.
  assign hand_over  = stat.done && (!out_valid || m_tready);
  assign ctrl.start = in_accept;
  assign ctrl.ack   = hand_over;

  mi_core #(
    .WIDTH (WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .a    (s_tdata[WIDTH-1:0]),
    .m    (s_tdata[2*WIDTH-1:WIDTH]),
    .stat (stat),
    .gcd  (core_gcd),
    .coef (core_coef)
  );

  // Euclid leaves |coef| <= modulus, so a single add or subtract brings it into range.
  assign mod_ext   = signed'({2'b00, modulus});
  assign coef_up   = core_coef + mod_ext;
  assign coef_down = core_coef - mod_ext;
  assign mod_zero  = (modulus == '0);

  always_comb begin
    if (mod_zero) begin
      inv_next = '0;
    end else if (core_coef[SW-1]) begin
      inv_next = coef_up[WIDTH-1:0];
    end else if (!coef_down[SW-1]) begin
      inv_next = coef_down[WIDTH-1:0];
    end else begin
      inv_next = core_coef[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        modulus <= s_tdata[2*WIDTH-1:WIDTH];
      end
      if (hand_over) begin
        out_valid   <= 1'b1;
        out_inverse <= inv_next;
        out_gcd     <= core_gcd;
        // zero modulus is out of range: never flag an inverse
        out_exists  <= !mod_zero && (core_gcd == WIDTH'(1));
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = OUT_W'({out_gcd, out_inverse});
  assign m_tuser[0] = out_exists;

`ifndef SYNTHESIS
  // One item at a time: the core goes busy straight after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input taken while an item is in flight");

  // A finished result is held by the core until the output register takes it.
  a_done_held: assert property (@(posedge clk) disable iff (rst)
    (stat.done && !hand_over) |=> stat.done)
    else $error("core result dropped before hand-over");

  // The existence flag agrees with the reported divisor.
  a_exists_gcd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[2*WIDTH-1:WIDTH] == WIDTH'(1)))
    else $error("inverse flagged with divisor other than one");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for modular_inverse: directed operand table, then random operand pairs.

module tb_top;

  // Geometry of the block under test: two WIDTH-bit fields packed into whole bytes.
  localparam int W  = 31;
  localparam int DW = ((2*W+7)/8)*8;
  localparam logic [W-1:0] FIELD_MAX = {W{1'b1}};

  // Run shape.
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 800;   // one long receiver hold-off, fills the block
  localparam int HOLD_AFTER   = 100;   // results seen before the hold-off starts
  localparam int DRAIN_CYCLES = 200;   // quiet time after the last result, > latency
  localparam int IDLE_LIMIT   = 5000;  // cycles with no item moving on either side
  localparam int PRINT_CAP    = 20;    // mismatch lines printed before going quiet
  localparam int N_ROWS       = 21;

  // Consecutive Fibonacci numbers: the longest Euclid chain that fits 31 bits.
  localparam logic [W-1:0] FIB_46 = 31'd1836311903;
  localparam logic [W-1:0] FIB_45 = 31'd1134903170;
  localparam logic [W-1:0] POW_30 = 31'd1073741824;

  // One operand pair and the result it should produce.
  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
    logic         exists;
  } inverse_item_t;

  // Directed row: operands, and a typed-in result where one is obvious.
  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic         known;
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
    logic         exists;
  } stim_row_t;

  stim_row_t directed_rows [N_ROWS] = '{
    // typed-in results: zero value, modulus one, unit value, and modulus zero
    // (out of the field range, but the behaviour is defined: divisor is the value)
    '{31'd0,     31'd1,     1'b1, 31'd0, 31'd1,     1'b1},
    '{31'd0,     FIELD_MAX, 1'b1, 31'd0, FIELD_MAX, 1'b0},
    '{FIELD_MAX, 31'd1,     1'b1, 31'd0, 31'd1,     1'b1},
    '{31'd1,     31'd1,     1'b1, 31'd0, 31'd1,     1'b1},
    '{31'd1,     FIELD_MAX, 1'b1, 31'd1, 31'd1,     1'b1},
    '{31'd12345, 31'd0,     1'b1, 31'd0, 31'd12345, 1'b0},
    '{FIELD_MAX, 31'd0,     1'b1, 31'd0, FIELD_MAX, 1'b0},
    '{31'd0,     31'd0,     1'b1, 31'd0, 31'd0,     1'b0},
    // predicted rows
    '{31'd2147483646,  FIELD_MAX,       1'b0, '0, '0, 1'b0},  // inverse of -1
    '{FIELD_MAX,       FIELD_MAX,       1'b0, '0, '0, 1'b0},
    '{31'd6,           31'd4,           1'b0, '0, '0, 1'b0},  // no inverse
    '{31'd3,           31'd7,           1'b0, '0, '0, 1'b0},
    '{31'd100,         31'd7,           1'b0, '0, '0, 1'b0},  // value above modulus
    '{FIB_46,          FIB_45,          1'b0, '0, '0, 1'b0},  // worst-case chain
    '{FIB_45,          FIB_46,          1'b0, '0, '0, 1'b0},
    '{POW_30,          FIELD_MAX,       1'b0, '0, '0, 1'b0},
    '{31'd1073741825,  POW_30,          1'b0, '0, '0, 1'b0},
    '{31'h5555_5555,   31'h2AAA_AAAA,   1'b0, '0, '0, 1'b0},  // alternating bits
    '{31'd123456789,   FIELD_MAX,       1'b0, '0, '0, 1'b0},
    '{31'd2,           POW_30,          1'b0, '0, '0, 1'b0},  // even divisor
    '{FIELD_MAX,       POW_30,          1'b0, '0, '0, 1'b0}
  };

  // Every input known from time zero; reset held from the start.
  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata  = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic [0:0]    m_tuser;

  inverse_item_t expected_inverses [$];
  int            error_count  = 0;
  int            results_seen = 0;

  modular_inverse #(.WIDTH(W)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // value, modulus, zero pad
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // inverse, common_divisor, zero pad
    .m_tuser  (m_tuser)    // inverse_exists
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Extended Euclid on 64-bit vectors; the coefficient wraps modulo 2^64 and its
  // true magnitude stays within the modulus, so the sign bit tells negatives apart.
  function automatic inverse_item_t predict_inverse(input logic [W-1:0] value,
                                                    input logic [W-1:0] modulus);
    inverse_item_t res;
    logic [63:0]   r0, r1, s0, s1, q, r2, s2, m64, rem;
    res.value   = value;
    res.modulus = modulus;
    if (modulus == '0) begin
      res.inverse = '0;
      res.divisor = value;
      res.exists  = 1'b0;
      return res;
    end
    m64 = 64'(modulus);
    r0  = 64'(value);
    r1  = m64;
    s0  = 64'd1;
    s1  = 64'd0;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      s2 = s0 - q * s1;
      r0 = r1;
      r1 = r2;
      s0 = s1;
      s1 = s2;
    end
    if (s0[63]) begin
      rem = (-s0) % m64;
      res.inverse = (rem == 64'd0) ? '0 : W'(m64 - rem);
    end else begin
      res.inverse = W'(s0 % m64);
    end
    res.divisor = W'(r0);
    res.exists  = (r0 == 64'd1);
    return res;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic report_mismatch(input string what, input inverse_item_t want,
                                 input logic [63:0] got, input logic [63:0] exp);
    if (error_count < PRINT_CAP)
      $display("tb_top: %s mismatch, value %0d modulus %0d: got %0d, expected %0d",
               what, want.value, want.modulus, got, exp);
    error_count++;
  endtask

  // Called at a rising edge. Holds the item until taken, then records its result.
  // With no gap, valid stays high and the next call only changes the data.
  task automatic offer_item(input inverse_item_t want, input int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= DW'({want.modulus, want.value});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_inverses.push_back(want);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: directed table, then random pairs, then wait for the block to drain.
  initial begin : stimulus
    inverse_item_t want;
    logic [W-1:0]  v, m;
    logic [63:0]   fa, fb, ft, g;
    int            pick, k, gap;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].known)
        want = '{directed_rows[i].value, directed_rows[i].modulus, directed_rows[i].inverse,
                 directed_rows[i].divisor, directed_rows[i].exists};
      else
        want = predict_inverse(directed_rows[i].value, directed_rows[i].modulus);
      offer_item(want, gap_length());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // full-width operands: every bit of both fields toggles
        v = W'($urandom());
        m = W'($urandom());
        if (m == '0) m = W'(1);
      end else if (pick < 60) begin
        // small operands, short runs
        v = W'($urandom_range(0, 255));
        m = W'($urandom_range(1, 255));
      end else if (pick < 70) begin
        // consecutive Fibonacci numbers give the longest quotient chains
        fa = 64'd1;
        fb = 64'd1;
        k  = $urandom_range(1, 44);
        repeat (k) begin
          ft = fa + fb;
          fa = fb;
          fb = ft;
        end
        if ($urandom_range(0, 1)) begin
          v = W'(fb);
          m = W'(fa);
        end else begin
          v = W'(fa);
          m = W'(fb);
        end
      end else if (pick < 82) begin
        // shared factor, so no inverse
        g = 64'($urandom_range(2, 1000));
        v = W'(g * $urandom_range(0, 2000000));
        m = W'(g * $urandom_range(1, 2000000));
      end else if (pick < 90) begin
        // powers of two against all-ones and power-of-two moduli
        v = W'(64'd1 << $urandom_range(0, W-1));
        case ($urandom_range(0, 2))
          0: m = FIELD_MAX;
          1: m = W'(64'd1 << $urandom_range(0, W-1));
          default: m = W'((64'd1 << $urandom_range(1, W)) - 64'd1);
        endcase
      end else begin
        // value zero, modulus one, value tied to the modulus
        m = W'($urandom());
        if (m == '0) m = W'(1);
        case ($urandom_range(0, 4))
          0: v = '0;
          1: begin
            m = W'(1);
            v = W'($urandom());
          end
          2: v = m;
          3: v = m - W'(1);
          default: v = W'(64'(m) * $urandom_range(2, 5));
        endcase
      end
      // stretches of back-to-back items between the gappy ones
      gap = ((n % 250) < 50) ? 0 : gap_length();
      offer_item(predict_inverse(v, m), gap);
    end
    s_tvalid <= 1'b0;

    while (expected_inverses.size() != 0) @(posedge clk);
    // anything arriving now has no expectation and is flagged by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_inverses.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off once traffic is flowing,
  // while the sender keeps offering so the block backs up to its input.
  initial begin : result_sink
    bit hold_done;
    int run, pick;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 99);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        for (int held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end else if (pick < 10) begin
        m_tready <= 1'b1;
        run = $urandom_range(100, 300);
        repeat (run - 1) @(posedge clk);
      end else if (pick < 70) begin
        m_tready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        run = gap_length() + 1;
        repeat (run - 1) @(posedge clk);
      end
    end
  end

  // Each result taken is compared with the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    inverse_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_inverses.size() == 0) begin
        want = '0;
        report_mismatch("unexpected item", want, 64'(m_tdata[W-1:0]), 64'd0);
      end else begin
        want = expected_inverses.pop_front();
        if (m_tdata[W-1:0] !== want.inverse)
          report_mismatch("inverse", want, 64'(m_tdata[W-1:0]), 64'(want.inverse));
        if (m_tdata[2*W-1:W] !== want.divisor)
          report_mismatch("common_divisor", want, 64'(m_tdata[2*W-1:W]), 64'(want.divisor));
        if (m_tuser[0] !== want.exists)
          report_mismatch("inverse_exists", want, 64'(m_tuser[0]), 64'(want.exists));
      end
    end
  end

  // Ends the run if no item moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/mi_pkg.sv
rtl/mi_core.sv
rtl/modular_inverse.sv
dv/tb_top.sv
